### hdl/mrat_pkg.sv
// Package for the MRU address range table: payload structs, table entry type,
// compare result type, sequencer states and shared constants. No dependencies.
package mrat_pkg;

    localparam int TABLE_ENTRIES_DEF = 8;
    localparam int ADDR_W            = 48;
    localparam int KIND_W            = 2;
    localparam int REMOVED_W         = 4;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] range_end;
        logic [KIND_W-1:0] range_kind;
        logic              range_readonly;
    } in_item_t;

    typedef struct packed {
        logic                 hit;
        logic [ADDR_W-1:0]    found_start;
        logic [ADDR_W-1:0]    found_end;
        logic [KIND_W-1:0]    found_kind;
        logic                 found_readonly;
        logic                 merged;
        logic [REMOVED_W-1:0] removed_count;
        logic                 evicted;
    } out_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] ent_start;
        logic [ADDR_W-1:0] ent_end;
        logic [KIND_W-1:0] ent_kind;
        logic              ent_readonly;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic contains;
        logic conflict;
    } match_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DROP_RD,
        ST_DROP_WR,
        ST_NEW,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FRONT,
        ST_RESP
    } state_t;

endpackage

### hdl/mrat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/mrat_match.sv
// Shared compare unit: containment of the item address in one table entry,
// and whether that entry conflicts with a range being inserted. Uses mrat_pkg.
module mrat_match
    import mrat_pkg::*;
(
    input  entry_t   ent,
    input  in_item_t item,
    output match_t   res
);

    always_comb begin
        res.contains = (ent.ent_start <= item.address) && (item.address <= ent.ent_end);
        res.conflict = (ent.ent_start != item.address) ||
                       (ent.ent_end > item.range_end) ||
                       (ent.ent_kind != item.range_kind) ||
                       (ent.ent_readonly != item.range_readonly);
    end

endmodule

### hdl/mru_address_range_table.sv
// MRU address range table top level: sequencer, entry RAM and compare unit.
// Depends on mrat_pkg, mrat_ram and mrat_match.
// Each entry compared passes a read and a check state and each entry moved a read and a
// write state, plus the new-entry, front-write and result-load states. One item at a time;
// reset empties the table.
module mru_address_range_table
    import mrat_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);
    localparam logic [REMOVED_W-1:0] REMOVED_MAX = '1;

    state_t          state_reg, state_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0] sh_reg, sh_next;
    in_item_t        item_reg, item_next;
    entry_t          hold_reg, hold_next;
    out_item_t       res_reg, res_next;
    logic            m_valid_reg, m_valid_next;
    out_item_t       m_data_reg, m_data_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata_raw;
    entry_t           ram_rdata;
    match_t           mt;

    logic [CNT_W-1:0] ptr_ext;
    logic [CNT_W-1:0] sh_ext;
    logic [CNT_W-1:0] new_fill;
    logic             table_full;

    mrat_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata_raw)
    );

    assign ram_rdata = entry_t'(ram_rdata_raw);

    mrat_match u_match (
        .ent (ram_rdata),
        .item(item_reg),
        .res (mt)
    );

    assign ptr_ext    = CNT_W'(ptr_reg);
    assign sh_ext     = CNT_W'(sh_reg);
    assign table_full = (used_reg == FULL_CNT);
    // Number of entries that slide down to make room at the front.
    assign new_fill   = table_full ? (FULL_CNT - CNT_W'(1)) : used_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        sh_reg     <= sh_next;
        item_reg   <= item_next;
        hold_reg   <= hold_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        used_next    = used_reg;
        ptr_next     = ptr_reg;
        sh_next      = sh_reg;
        item_next    = item_reg;
        hold_next    = hold_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = sh_reg;
        ram_wdata    = ram_rdata;
        ram_raddr    = ptr_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    ptr_next   = '0;
                    res_next   = '0;
                    state_next = (used_reg == '0) ? ST_NEW : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                ram_raddr  = ptr_reg;
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (mt.contains && (item_reg.func == FUNC_LOOKUP || !mt.conflict)) begin
                    hold_next = ram_rdata;
                    if (item_reg.func == FUNC_LOOKUP) begin
                        res_next.hit            = 1'b1;
                        res_next.found_start    = ram_rdata.ent_start;
                        res_next.found_end      = ram_rdata.ent_end;
                        res_next.found_kind     = ram_rdata.ent_kind;
                        res_next.found_readonly = ram_rdata.ent_readonly;
                    end else begin
                        hold_next.ent_end = item_reg.range_end;
                        res_next.merged   = 1'b1;
                    end
                    if (ptr_reg == '0) begin
                        state_next = ST_FRONT;
                    end else begin
                        sh_next    = ptr_reg - IDX_W'(1);
                        state_next = ST_SHIFT_RD;
                    end
                end else if (mt.contains) begin
                    // Conflicting entry: remove it, then resume the scan at the same slot if entries remain.
                    if (res_reg.removed_count != REMOVED_MAX) begin
                        res_next.removed_count = res_reg.removed_count + REMOVED_W'(1);
                    end
                    if (ptr_ext + CNT_W'(1) < used_reg) begin
                        sh_next    = ptr_reg + IDX_W'(1);
                        state_next = ST_DROP_RD;
                    end else begin
                        used_next  = used_reg - CNT_W'(1);
                        state_next = ST_NEW;
                    end
                end else if (ptr_ext + CNT_W'(1) < used_reg) begin
                    ptr_next   = ptr_reg + IDX_W'(1);
                    state_next = ST_SCAN_RD;
                end else begin
                    state_next = ST_NEW;
                end
            end
            ST_DROP_RD: begin
                ram_raddr  = sh_reg;
                state_next = ST_DROP_WR;
            end
            ST_DROP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = sh_reg - IDX_W'(1);
                ram_wdata = ram_rdata;
                if (sh_ext == used_reg - CNT_W'(1)) begin
                    used_next = used_reg - CNT_W'(1);
                    if (ptr_ext < used_reg - CNT_W'(1)) begin
                        state_next = ST_SCAN_RD;
                    end else begin
                        state_next = ST_NEW;
                    end
                end else begin
                    sh_next    = sh_reg + IDX_W'(1);
                    state_next = ST_DROP_RD;
                end
            end
            ST_NEW: begin
                if (item_reg.func == FUNC_LOOKUP) begin
                    state_next = ST_RESP;
                end else begin
                    hold_next.ent_start    = item_reg.address;
                    hold_next.ent_end      = item_reg.range_end;
                    hold_next.ent_kind     = item_reg.range_kind;
                    hold_next.ent_readonly = item_reg.range_readonly;
                    res_next.evicted       = table_full;
                    used_next              = new_fill + CNT_W'(1);
                    if (new_fill == '0) begin
                        state_next = ST_FRONT;
                    end else begin
                        sh_next    = IDX_W'(new_fill - CNT_W'(1));
                        state_next = ST_SHIFT_RD;
                    end
                end
            end
            ST_SHIFT_RD: begin
                ram_raddr  = sh_reg;
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = sh_reg + IDX_W'(1);
                ram_wdata = ram_rdata;
                if (sh_reg == '0) begin
                    state_next = ST_FRONT;
                end else begin
                    sh_next    = sh_reg - IDX_W'(1);
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_FRONT: begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = hold_reg;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                // The result waits here until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/mrat_checker.sv
// Port-level checker for the MRU address range table, bound to the top level.
// Depends on mrat_pkg and mru_address_range_table.
module mrat_checker
    import mrat_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input transfer taken while an item was in progress");

    a_hit_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.hit) |->
            (!m_data.merged && !m_data.evicted && m_data.removed_count == '0))
        else $error("lookup hit carries insert flags");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.hit) |->
            (m_data.found_start == '0 && m_data.found_end == '0 &&
             m_data.found_kind == '0 && !m_data.found_readonly))
        else $error("found fields not zero without a hit");

    // A merge reuses an entry, so nothing can have been evicted.
    a_merge_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.merged && m_data.evicted))
        else $error("merge and eviction reported together");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

endmodule

bind mru_address_range_table mrat_checker u_mrat_checker (.*);
